// File: sv/mpm_pkg.sv
package mpm_pkg;

	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_STATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd2;

	localparam logic [1:0] CFG_STOP  = 2'd0;
	localparam logic [1:0] CFG_FOLD  = 2'd1;
	localparam logic [1:0] CFG_PBASE = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [10:0] entry_index;
		logic [9:0]  fail_state;
		logic [7:0]  pattern_len;
		logic [10:0] edge_base;
		logic [8:0]  edge_count;
		logic [7:0]  edge_label;
		logic [9:0]  target_state;
		logic [7:0]  text_byte;
		logic        text_last;
	} in_item_t;

	typedef struct packed {
		logic        match_found;
		logic [15:0] match_start;
		logic [15:0] match_end;
		logic [9:0]  match_id;
		logic [9:0]  final_state;
		logic        end_of_text;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SREAD,
		ST_SWAIT,
		ST_EWAIT,
		ST_LREAD,
		ST_LWAIT,
		ST_DONE
	} fsm_t;

endpackage

// File: sv/multi_pattern_matcher.sv
// multi_pattern_matcher: streaming Aho-Corasick search over a preloaded automaton.
// Input channel (in_valid/in_stall, payload in_item) carries three kinds of item:
// state record writes, edge writes and text bytes. A write gives no result;
// writes can follow back to back. A text byte walks the automaton: one
// state-memory read, then a scan of the state's edges in the edge memory (at
// least one edge read per state visited), another state read per fail link
// followed, and one more state read for the pattern length of the landing
// state. The block takes no new item until that walk is done. A byte that
// arrives after a first match in stop mode skips the walk.
// Output channel (out_valid/out_stall, payload out_item) carries one item for a
// byte that matches or closes a text; other bytes give none. The result sits in
// an output register; while it waits on a stalled receiver, text bytes are held
// off and writes are still accepted.
// Config writes (cfg_we, cfg_index, cfg_data) only while idle.
// Reset clears the search state and config, but sets stop mode on; the memories
// hold no reset value and must be loaded before searching. No clearing pass.
module multi_pattern_matcher #(
	parameter int NUM_STATES      = 1024,
	parameter int NUM_EDGES       = 2048,
	parameter int MAX_PATTERN_LEN = 255,
	parameter int POS_BITS        = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mpm_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mpm_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import mpm_pkg::*;

	localparam int SB = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
	localparam int EB = (NUM_EDGES > 2) ? $clog2(NUM_EDGES) : 1;
	localparam logic [POS_BITS:0] POS_MAX = {1'b0, {POS_BITS{1'b1}}};
	localparam int HB = SB + 1;

	typedef struct packed {
		logic [9:0]  fail;
		logic [7:0]  len;
		logic [10:0] base;
		logic [8:0]  count;
	} srec_t;

	typedef struct packed {
		logic [7:0] label;
		logic [9:0] target;
	} erec_t;

	srec_t smem [NUM_STATES];
	erec_t emem [NUM_EDGES];

	logic          s_we, e_we;
	logic [SB-1:0] s_wa, s_ra;
	logic [EB-1:0] e_wa, e_ra;
	srec_t         s_wd, s_rd_q;
	erec_t         e_wd, e_rd_q;

	always_ff @(posedge clk) begin
		if (s_we)
			smem[s_wa] <= s_wd;
		s_rd_q <= smem[s_ra];
	end

	always_ff @(posedge clk) begin
		if (e_we)
			emem[e_wa] <= e_wd;
		e_rd_q <= emem[e_ra];
	end

	fsm_t state_q, state_d;
	logic [SB-1:0] cur_q, cur_d;
	logic [POS_BITS-1:0] tpos_q, tpos_d;
	logic stopped_q, stopped_d, intext_q, intext_d;
	logic stop_cfg_q, fold_q;
	logic [15:0] pbase_q;
	logic [7:0] c_q, c_d;
	logic last_q, last_d;
	logic [SB-1:0] s_q, s_d;
	logic [11:0] eidx_q, eidx_d;
	logic [8:0] left_q, left_d;
	logic [HB-1:0] hops_q, hops_d;
	logic [9:0] fail_q, fail_d;
	logic ov_q, ov_d;
	out_item_t oi_q, oi_d;

	logic accept;
	logic [7:0] cf;
	logic [POS_BITS:0] pos, pos1;
	logic [8:0] lenc;
	logic [POS_BITS:0] start;
	logic [SB-1:0] tgt;
	logic [SB-1:0] fl;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (state_q == ST_IDLE && ov_q && out_stall
		&& in_item.req_type == REQ_BYTE);
	assign out_valid = ov_q;
	assign out_item  = oi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cfg_q <= 1'b1;
			fold_q     <= 1'b0;
			pbase_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STOP:  stop_cfg_q <= cfg_data[0];
				CFG_FOLD:  fold_q     <= cfg_data[0];
				CFG_PBASE: pbase_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			tpos_q    <= '0;
			stopped_q <= 1'b0;
			intext_q  <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			tpos_q    <= tpos_d;
			stopped_q <= stopped_d;
			intext_q  <= intext_d;
			ov_q      <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		c_q    <= c_d;
		last_q <= last_d;
		s_q    <= s_d;
		eidx_q <= eidx_d;
		left_q <= left_d;
		hops_q <= hops_d;
		fail_q <= fail_d;
		oi_q   <= oi_d;
	end

	always_comb begin
		cf = in_item.text_byte;
		if (fold_q && cf >= 8'h41 && cf <= 8'h5A)
			cf = cf + 8'h20;
		if (intext_q)
			pos = {1'b0, tpos_q};
		else if (32'(pbase_q) > 32'(POS_MAX))
			pos = POS_MAX;
		else
			pos = (POS_BITS+1)'(pbase_q);
		pos1 = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
		lenc = (32'(s_rd_q.len) > MAX_PATTERN_LEN) ? 9'(MAX_PATTERN_LEN)
			: {1'b0, s_rd_q.len};
		start = ((POS_BITS+1)'(lenc) <= pos + 1'b1) ? pos + 1'b1 - (POS_BITS+1)'(lenc)
			: '0;
		tgt = (32'(e_rd_q.target) < NUM_STATES) ? SB'(e_rd_q.target) : '0;
		fl  = (32'(fail_q) < NUM_STATES) ? SB'(fail_q) : '0;
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		tpos_d    = tpos_q;
		stopped_d = stopped_q;
		intext_d  = intext_q;
		ov_d      = ov_q && out_stall;
		c_d       = c_q;
		last_d    = last_q;
		s_d       = s_q;
		eidx_d    = eidx_q;
		left_d    = left_q;
		hops_d    = hops_q;
		fail_d    = fail_q;
		oi_d      = oi_q;
		s_we = 1'b0;
		e_we = 1'b0;
		s_wa = SB'(in_item.entry_index);
		e_wa = EB'(in_item.entry_index);
		s_wd = '{fail: in_item.fail_state, len: in_item.pattern_len,
			base: in_item.edge_base, count: in_item.edge_count};
		e_wd = '{label: in_item.edge_label, target: in_item.target_state};
		s_ra = s_q;
		e_ra = EB'(eidx_q);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_item.req_type)
						REQ_STATE: s_we = 32'(in_item.entry_index) < NUM_STATES;
						REQ_EDGE:  e_we = 32'(in_item.entry_index) < NUM_EDGES;
						REQ_BYTE: begin
							c_d    = cf;
							last_d = in_item.text_last;
							if (stopped_q) begin
								state_d = ST_DONE;
							end else begin
								s_d     = cur_q;
								hops_d  = '0;
								state_d = ST_SREAD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SREAD: begin
				s_ra    = s_q;
				state_d = ST_SWAIT;
			end
			ST_SWAIT: begin
				fail_d  = s_rd_q.fail;
				eidx_d  = {1'b0, s_rd_q.base};
				left_d  = s_rd_q.count;
				e_ra    = EB'(s_rd_q.base);
				state_d = ST_EWAIT;
				if (s_rd_q.count == '0 || 32'(s_rd_q.base) >= NUM_EDGES)
					left_d = '0;
			end
			ST_EWAIT: begin
				if (left_q != '0 && e_rd_q.label == c_q) begin
					s_d     = tgt;
					state_d = ST_LREAD;
				end else if (left_q > 9'd1 && 32'(eidx_q) + 1 < NUM_EDGES) begin
					eidx_d = eidx_q + 1'b1;
					left_d = left_q - 1'b1;
					e_ra   = EB'(eidx_q + 1'b1);
				end else if (s_q == '0) begin
					state_d = ST_LREAD;
				end else begin
					if (32'(hops_q) >= NUM_STATES) begin
						s_d = '0;
					end else begin
						s_d    = fl;
						hops_d = hops_q + 1'b1;
					end
					state_d = ST_SREAD;
				end
			end
			ST_LREAD: begin
				s_ra    = s_q;
				state_d = ST_LWAIT;
			end
			ST_LWAIT: begin
				cur_d = s_q;
				oi_d  = '0;
				oi_d.final_state = 10'(s_q);
				oi_d.end_of_text = last_q;
				if (lenc != '0) begin
					oi_d.match_found = 1'b1;
					oi_d.match_start = 16'(start);
					oi_d.match_end   = 16'(pos1);
					oi_d.match_id    = 10'(s_q);
					if (stop_cfg_q)
						stopped_d = 1'b1;
				end
				if (lenc != '0 || last_q)
					ov_d = 1'b1;
				if (last_q) begin
					cur_d     = '0;
					tpos_d    = '0;
					stopped_d = 1'b0;
					intext_d  = 1'b0;
				end else begin
					tpos_d   = POS_BITS'(pos1);
					intext_d = 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_DONE: begin
				if (last_q) begin
					oi_d = '0;
					oi_d.final_state = 10'(cur_q);
					oi_d.end_of_text = 1'b1;
					ov_d      = 1'b1;
					cur_d     = '0;
					tpos_d    = '0;
					stopped_d = 1'b0;
					intext_d  = 1'b0;
				end else begin
					tpos_d   = POS_BITS'(pos1);
					intext_d = 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: tb/mpm_match_checker.sv
module mpm_match_checker
	import mpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSTATES = 1024;
	localparam int NEDGES  = 2048;
	localparam logic [16:0] POS_TOP = 17'h0FFFF;

	logic [9:0]  st_fail [NSTATES];
	logic [7:0]  st_len  [NSTATES];
	logic [10:0] st_base [NSTATES];
	logic [8:0]  st_cnt  [NSTATES];
	logic [7:0]  ed_lab  [NEDGES];
	logic [9:0]  ed_tgt  [NEDGES];

	logic [9:0]  cur_state;
	logic [16:0] text_pos;
	logic        frozen;
	logic        in_text;
	logic        stop_first;
	logic        fold;
	logic [15:0] pos_base;

	out_item_t expected_matches[$];

	function automatic logic [9:0] walk_automaton(logic [9:0] s0, logic [7:0] c);
		logic [9:0] s;
		int hops;
		int e;
		s = s0;
		hops = 0;
		forever begin
			for (int k = 0; k < int'(st_cnt[s]); k++) begin
				e = int'(st_base[s]) + k;
				if (e >= NEDGES)
					break;
				if (ed_lab[e] == c)
					return ed_tgt[e];
			end
			if (s == 0)
				return '0;
			if (hops >= NSTATES) begin
				s = '0;
			end else begin
				s = st_fail[s];
				hops++;
			end
		end
	endfunction

	task automatic predict_item(in_item_t it);
		out_item_t r;
		logic [7:0] c;
		logic [16:0] pos;
		logic [7:0] len;
		logic hit;
		case (it.req_type)
			REQ_STATE: begin
				if (it.entry_index < NSTATES) begin
					st_fail[it.entry_index] = it.fail_state;
					st_len[it.entry_index]  = it.pattern_len;
					st_base[it.entry_index] = it.edge_base;
					st_cnt[it.entry_index]  = it.edge_count;
				end
			end
			REQ_EDGE: begin
				ed_lab[it.entry_index] = it.edge_label;
				ed_tgt[it.entry_index] = it.target_state;
			end
			REQ_BYTE: begin
				c = it.text_byte;
				if (fold && c >= 8'h41 && c <= 8'h5A)
					c = c + 8'h20;
				pos = in_text ? text_pos : {1'b0, pos_base};
				hit = 1'b0;
				r = '0;
				if (!frozen) begin
					cur_state = walk_automaton(cur_state, c);
					len = st_len[cur_state];
					if (len != 0) begin
						hit = 1'b1;
						r.match_found = 1'b1;
						r.match_end = (pos < POS_TOP) ? 16'(pos + 17'd1) : 16'(POS_TOP);
						r.match_start = ({9'd0, len} <= pos + 17'd1) ?
							16'(pos + 17'd1 - {9'd0, len}) : 16'd0;
						r.match_id = cur_state;
						if (stop_first)
							frozen = 1'b1;
					end
				end
				r.final_state = cur_state;
				r.end_of_text = it.text_last;
				if (hit || it.text_last)
					expected_matches.push_back(r);
				if (it.text_last) begin
					cur_state = '0;
					text_pos = '0;
					frozen = 1'b0;
					in_text = 1'b0;
				end else begin
					text_pos = (pos < POS_TOP) ? pos + 17'd1 : POS_TOP;
					in_text = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		logic bad;
		if (expected_matches.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%t unexpected result %p", $realtime, got);
		end else begin
			want = expected_matches.pop_front();
			bad = (got.match_found !== want.match_found) ||
				(got.match_start !== want.match_start) ||
				(got.match_end !== want.match_end) ||
				(got.match_id !== want.match_id) ||
				(got.final_state !== want.final_state) ||
				(got.end_of_text !== want.end_of_text);
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display("%t mismatch: expected %p got %p", $realtime, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state = '0;
			text_pos = '0;
			frozen = 1'b0;
			in_text = 1'b0;
			stop_first = 1'b1;
			fold = 1'b0;
			pos_base = '0;
			expected_matches.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STOP:  stop_first = cfg_data[0];
					CFG_FOLD:  fold = cfg_data[0];
					CFG_PBASE: pos_base = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item(in_item);
			if (out_valid && !out_stall)
				check_result(out_item);
			pending = expected_matches.size();
		end
	end

endmodule

// File: tb/multi_pattern_matcher_tb.sv
module multi_pattern_matcher_tb;
	import mpm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 100000;
	localparam int DRAIN = 8000;
	localparam int PHASES = 6;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;

	int mode;
	bit hold_req;
	int quiet = 0;
	int ids[$];

	multi_pattern_matcher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mpm_match_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		int hold_len;
		bit held;
		hold_len = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				hold_len = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else begin
				out_stall <= (mode == 2) ? ($urandom_range(99) < 86) :
					(mode == 3) ? ($urandom_range(99) < 20) : 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic in_item_t noise_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	task automatic send(in_item_t it);
		int idle_pct;
		idle_pct = (mode == 1) ? 86 : (mode == 3) ? 20 : 0;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_state(int idx, int fail, int len, int base, int cnt);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_STATE;
		it.entry_index = 11'(idx);
		it.fail_state = 10'(fail);
		it.pattern_len = 8'(len);
		it.edge_base = 11'(base);
		it.edge_count = 9'(cnt);
		send(it);
	endtask

	task automatic write_edge(int idx, logic [7:0] lab, int tgt);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_EDGE;
		it.entry_index = 11'(idx);
		it.edge_label = lab;
		it.target_state = 10'(tgt);
		send(it);
	endtask

	task automatic send_byte(logic [7:0] c, logic last);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_BYTE;
		it.text_byte = c;
		it.text_last = last;
		send(it);
	endtask

	// items the block drops: unknown request or state index past the table
	task automatic send_ignored();
		in_item_t it;
		it = noise_item();
		if ($urandom_range(1)) begin
			it.req_type = REQ_NONE;
		end else begin
			it.req_type = REQ_STATE;
			it.entry_index = 11'($urandom_range(1024, 2047));
		end
		send(it);
	endtask

	// small automaton; every record only points at written states and edges
	task automatic load_tables();
		int k, n, cur, big, base, cnt, fail, len;
		bit dup;
		logic [7:0] lab;
		logic [7:0] labs[$];
		ids.delete();
		ids.push_back(0);
		if ($urandom_range(2) == 0)
			ids.push_back(1023);
		k = $urandom_range(3, 8);
		while (ids.size() < k) begin
			n = $urandom_range(1, 1023);
			dup = 0;
			foreach (ids[j])
				if (ids[j] == n)
					dup = 1;
			if (!dup)
				ids.push_back(n);
		end
		cur = $urandom_range(0, 200);
		big = $urandom_range(1) ? $urandom_range(1, ids.size() - 1) : -1;
		foreach (ids[i]) begin
			labs.delete();
			if (i == big) begin
				n = $urandom_range(1, 3);
				base = 2048 - n;
				cnt = $urandom_range(n, 256);
			end else begin
				n = $urandom_range((i == 0) ? 2 : 0, 4);
				base = cur;
				cnt = n;
				cur += n;
			end
			while (labs.size() < n) begin
				lab = ($urandom_range(7) == 0) ? 8'($urandom_range(0, 255)) :
					8'h61 + 8'($urandom_range(0, 4));
				dup = 0;
				foreach (labs[j])
					if (labs[j] == lab)
						dup = 1;
				if (!dup)
					labs.push_back(lab);
			end
			labs.sort();
			foreach (labs[j])
				write_edge(base + j, labs[j], ids[$urandom_range(0, ids.size() - 1)]);
			fail = $urandom_range(1) ? 0 : ids[$urandom_range(0, ids.size() - 1)];
			len = (i == 0 || $urandom_range(1)) ? 0 : $urandom_range(1, 255);
			write_state(ids[i], fail, len, base, cnt);
		end
	endtask

	task automatic write_config(logic stop, logic fold, logic [15:0] base);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STOP;
		cfg_data <= {15'd0, stop};
		@(posedge clk);
		cfg_index <= CFG_FOLD;
		cfg_data <= {15'd0, fold};
		@(posedge clk);
		cfg_index <= CFG_PBASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		wait (pending == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		logic [0:PHASES-1] stop_set;
		logic [0:PHASES-1] fold_set;
		logic [15:0] base_set[PHASES];
		int sent, tlen;
		logic [7:0] c;
		stop_set = 6'b100101;
		fold_set = 6'b010101;
		base_set = '{16'd0, 16'd65535, 16'd65530, 16'd12345, 16'd0, 16'd0};
		base_set[5] = 16'($urandom);
		mode = 0;
		hold_req = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			mode = p % 4;
			write_config(stop_set[p], fold_set[p], base_set[p]);
			load_tables();
			if (p == 0) begin
				send_ignored();
				send_ignored();
				send_byte(8'h00, 1'b0);
				send_byte(8'hFF, 1'b0);
				send_byte(8'h61, 1'b0);
				send_byte(8'h41, 1'b1);
				send_byte(8'h62, 1'b1);
			end
			if (p == 4)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 40) begin
				tlen = $urandom_range(1, 12);
				for (int b = 0; b < tlen; b++) begin
					if ($urandom_range(19) == 0)
						send_ignored();
					if ($urandom_range(19) == 0) begin
						c = 8'($urandom_range(0, 255));
					end else begin
						c = 8'h61 + 8'($urandom_range(0, 4));
						if ($urandom_range(1))
							c = c - 8'h20;
					end
					send_byte(c, b == tlen - 1);
					sent++;
				end
			end
			in_valid <= 1'b0;
			settle();
		end
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
